// ===== design/rha_pkg.sv =====
// Shared types and constants for the reference-counted handle allocator.
// No dependencies; every other design file imports this package.
`timescale 1ns / 1ps

package rha_pkg;

  // Default pool geometry; the top level takes these as parameter defaults.
  localparam int unsigned SLOTS_DEF      = 256;
  localparam int unsigned COUNT_BITS_DEF = 16;

  // Fixed transaction field widths.
  localparam int unsigned HANDLE_W    = 8;
  localparam int unsigned COUNT_OUT_W = 16;

  typedef enum logic [2:0] {
    ACT_ALLOC   = 3'd0,
    ACT_RETAIN  = 3'd1,
    ACT_RELEASE = 3'd2,
    ACT_REMOVE  = 3'd3,
    ACT_QUERY   = 3'd4
  } rha_action_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FULL   = 2'd1,
    STAT_ABSENT = 2'd2
  } rha_status_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } rha_state_e;

  typedef struct packed {
    rha_action_e         action;
    logic [HANDLE_W-1:0] handle;
  } rha_in_t;

  typedef struct packed {
    rha_status_e            status;
    logic [HANDLE_W-1:0]    slot_out;
    logic                   slot_freed;
    logic [COUNT_OUT_W-1:0] count_out;
  } rha_out_t;

endpackage

// ===== design/refcounted_handle_allocator.sv =====
// A transaction is accepted only in the idle state; its result is registered in the
// execute state that follows (memory read, then modify and write back), and the input
// stays stalled until then, longer while the output register is held by a stall.
// Reset: control registers clear at once; the count memory is not swept, a
// high-water mark of ever-used slots marks entries that were never written.
`timescale 1ns / 1ps

module refcounted_handle_allocator
  import rha_pkg::*;
#(
  parameter int unsigned SLOTS      = SLOTS_DEF,
  parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  rha_in_t  in_item_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output rha_out_t out_item_o
);

  localparam int unsigned IDX_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = IDX_W + 1;
  localparam int unsigned WRD_W = COUNT_BITS + 1;

  // Control state
  rha_state_e state_q, state_d;
  logic [CNT_W-1:0] free_top_q, free_top_d;
  logic [CNT_W-1:0] live_q, live_d;
  logic [CNT_W-1:0] hwm_q, hwm_d;     // slots below this mark have been written
  logic             out_valid_q, out_valid_d;

  // Captured transaction and result register
  rha_action_e         act_q;
  logic [HANDLE_W-1:0] hdl_q;
  rha_out_t            out_q, out_d;

  // Memory ports
  logic             accept;
  logic             cnt_we;
  logic [IDX_W-1:0] cnt_waddr;
  logic [WRD_W-1:0] cnt_wdata;
  logic [WRD_W-1:0] cnt_rdata;
  logic             stk_we;
  logic [IDX_W-1:0] stk_waddr;
  logic [IDX_W-1:0] stk_rdata;
  logic [CNT_W-1:0] top_m1;

  // Execute-stage decode
  logic                  out_free;
  logic                  in_range;
  logic [IDX_W-1:0]      idx;
  logic                  present;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic [COUNT_BITS-1:0] cnt_dec;
  logic [IDX_W-1:0]      alloc_slot;
  logic                  do_free;

  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign in_stall_o = (state_q != ST_IDLE);
  assign top_m1     = free_top_q - CNT_W'(1);

  // Slot word: {live flag, reference count}
  rha_ram #(
    .WIDTH(WRD_W),
    .DEPTH(SLOTS)
  ) u_count_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .re_i   (accept),
    .raddr_i(IDX_W'(in_item_i.handle)),
    .rdata_o(cnt_rdata)
  );

  // LIFO of freed slot numbers; always read at the current top
  rha_ram #(
    .WIDTH(IDX_W),
    .DEPTH(SLOTS)
  ) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(idx),
    .re_i   (accept),
    .raddr_i(top_m1[IDX_W-1:0]),
    .rdata_o(stk_rdata)
  );

  assign out_free = !out_valid_q || !out_stall_i;
  assign in_range = (32'(hdl_q) < SLOTS);
  assign idx      = IDX_W'(hdl_q);
  // Entries at or above the high-water mark were never written: treat as free.
  assign present  = in_range && ({1'b0, idx} < hwm_q) && cnt_rdata[COUNT_BITS];
  assign cnt      = cnt_rdata[COUNT_BITS-1:0];
  assign cnt_inc  = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + COUNT_BITS'(1);
  assign cnt_dec  = cnt - COUNT_BITS'(1);
  assign alloc_slot = (free_top_q != '0) ? stk_rdata : live_q[IDX_W-1:0];

  always_comb begin
    state_d     = state_q;
    free_top_d  = free_top_q;
    live_d      = live_q;
    hwm_d       = hwm_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    cnt_we      = 1'b0;
    cnt_waddr   = idx;
    cnt_wdata   = '0;
    stk_we      = 1'b0;
    stk_waddr   = free_top_q[IDX_W-1:0];
    do_free     = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (!(act_q inside {ACT_ALLOC, ACT_RETAIN, ACT_RELEASE, ACT_REMOVE, ACT_QUERY})) begin
          // Undefined action: drop without a result
          state_d = ST_IDLE;
        end else if (out_free) begin
          state_d          = ST_IDLE;
          out_valid_d      = 1'b1;
          out_d.status     = STAT_OK;
          out_d.slot_out   = hdl_q;
          out_d.slot_freed = 1'b0;
          out_d.count_out  = '0;
          if (act_q == ACT_ALLOC) begin
            if (live_q == CNT_W'(SLOTS)) begin
              out_d.status   = STAT_FULL;
              out_d.slot_out = '0;
            end else begin
              if (free_top_q != '0) begin
                free_top_d = top_m1;
              end else begin
                hwm_d = hwm_q + CNT_W'(1);
              end
              live_d          = live_q + CNT_W'(1);
              cnt_we          = 1'b1;
              cnt_waddr       = alloc_slot;
              cnt_wdata       = {1'b1, COUNT_BITS'(1)};
              out_d.slot_out  = HANDLE_W'(alloc_slot);
              out_d.count_out = COUNT_OUT_W'(1);
            end
          end else if (!present) begin
            out_d.status = STAT_ABSENT;
          end else begin
            case (act_q)
              ACT_RETAIN: begin
                cnt_we          = 1'b1;
                cnt_wdata       = {1'b1, cnt_inc};
                out_d.count_out = COUNT_OUT_W'(cnt_inc);
              end
              ACT_RELEASE: begin
                if (cnt > COUNT_BITS'(1)) begin
                  cnt_we          = 1'b1;
                  cnt_wdata       = {1'b1, cnt_dec};
                  out_d.count_out = COUNT_OUT_W'(cnt_dec);
                end else begin
                  do_free = 1'b1;
                end
              end
              ACT_REMOVE: begin
                do_free = 1'b1;
              end
              default: begin
                out_d.count_out = COUNT_OUT_W'(cnt);
              end
            endcase
            if (do_free) begin
              // Clear the slot and push it onto the free stack
              cnt_we           = 1'b1;
              cnt_wdata        = '0;
              out_d.slot_freed = 1'b1;
              if (free_top_q != CNT_W'(SLOTS)) begin
                stk_we     = 1'b1;
                free_top_d = free_top_q + CNT_W'(1);
              end
              if (live_q != '0) begin
                live_d = live_q - CNT_W'(1);
              end
            end
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      free_top_q  <= '0;
      live_q      <= '0;
      hwm_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      free_top_q  <= free_top_d;
      live_q      <= live_d;
      hwm_q       <= hwm_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on accept, hold the result while stalled
  always_ff @(posedge clk_i) begin
    if (accept) begin
      act_q <= in_item_i.action;
      hdl_q <= in_item_i.handle;
    end
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

// ===== design/rha_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on rha_pkg for its default parameter values.
`timescale 1ns / 1ps

module rha_ram
  import rha_pkg::*;
#(
  parameter int unsigned WIDTH = COUNT_BITS_DEF,
  parameter int unsigned DEPTH = SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== tb/tb_refcounted_handle_allocator.sv =====
// Self-checking testbench for the reference-counted handle allocator.
// Depends on rha_pkg and refcounted_handle_allocator; a predictor checks every result.
`timescale 1ns / 1ps

module tb_refcounted_handle_allocator;
  import rha_pkg::*;

  localparam int unsigned POOL_SLOTS = SLOTS_DEF;
  localparam int unsigned CNT_BITS   = COUNT_BITS_DEF;

  // Two copies of the allocator state: one runs ahead while stimulus is built,
  // so that handles can be aimed at live slots; the other follows the accepted
  // transactions and predicts the replies.
  localparam int PLAN_COPY  = 0;
  localparam int CHECK_COPY = 1;

  localparam logic [2:0] FIRST_UNDEF_ACT = 3'(ACT_QUERY) + 3'd1;

  localparam int unsigned TAIL_ITEMS   = 200;  // no idling over the last transactions
  localparam int unsigned HOLD_AT      = 600;  // start of the long receiver hold-off
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned STUCK_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned PHASE_ITEMS  = 100;

  typedef enum logic [1:0] {
    MIX_GROW,
    MIX_BALANCED,
    MIX_SHRINK
  } mix_e;

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  rha_in_t  in_item_i   = '0;
  logic     out_stall_i = 1'b0;
  logic     in_stall_o;
  logic     out_valid_o;
  rha_out_t out_item_o;

  // Predictor state, per copy
  logic                slot_live   [2][POOL_SLOTS];
  logic [CNT_BITS-1:0] slot_count  [2][POOL_SLOTS];
  int unsigned         free_stack  [2][POOL_SLOTS];
  int unsigned         stack_depth [2];
  int unsigned         live_total  [2];

  rha_in_t     action_queue[$];       // transactions still to be offered
  rha_out_t    predicted_replies[$];  // replies owed by the block, oldest first
  int unsigned fail_count     = 0;
  int unsigned accepted_items = 0;
  int unsigned cycle_count    = 0;
  int unsigned stuck_cycles   = 0;
  int unsigned tx_gap_left    = 0;
  int unsigned rx_gap_left    = 0;
  logic        all_sent       = 1'b0;
  logic        tail_phase     = 1'b0;
  logic        long_hold_on   = 1'b0;
  logic        long_hold_done = 1'b0;

  refcounted_handle_allocator #(
    .SLOTS      (POOL_SLOTS),
    .COUNT_BITS (CNT_BITS)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Apply one transaction to copy c of the allocator; return 0 for codes that
  // give no reply.
  function automatic bit apply_action(int c, rha_in_t item, output rha_out_t reply);
    int unsigned s;
    reply          = '0;
    reply.slot_out = item.handle;
    case (item.action)
      ACT_ALLOC: begin
        reply.slot_out = '0;
        if (live_total[c] >= POOL_SLOTS) begin
          reply.status = STAT_FULL;
        end else begin
          // Reuse the most recently freed slot, else the next never-used one
          if (stack_depth[c] > 0) begin
            stack_depth[c]--;
            s = free_stack[c][stack_depth[c]];
          end else begin
            s = live_total[c];
          end
          slot_live[c][s]  = 1'b1;
          slot_count[c][s] = CNT_BITS'(1);
          live_total[c]++;
          reply.status    = STAT_OK;
          reply.slot_out  = HANDLE_W'(s);
          reply.count_out = COUNT_OUT_W'(1);
        end
      end
      ACT_RETAIN, ACT_RELEASE, ACT_REMOVE, ACT_QUERY: begin
        s = 32'(item.handle);
        if (s >= POOL_SLOTS || !slot_live[c][s]) begin
          reply.status = STAT_ABSENT;
        end else begin
          reply.status = STAT_OK;
          if (item.action == ACT_RETAIN && slot_count[c][s] != '1) begin
            slot_count[c][s]++;
          end else if (item.action == ACT_RELEASE && slot_count[c][s] > 1) begin
            slot_count[c][s]--;
          end else if (item.action != ACT_QUERY && item.action != ACT_RETAIN) begin
            // Remove, or release of the last reference: back onto the free stack
            slot_live[c][s]  = 1'b0;
            slot_count[c][s] = '0;
            if (stack_depth[c] < POOL_SLOTS) begin
              free_stack[c][stack_depth[c]] = s;
              stack_depth[c]++;
            end
            if (live_total[c] > 0) live_total[c]--;
            reply.slot_freed = 1'b1;
          end
          reply.count_out = COUNT_OUT_W'(slot_count[c][s]);
        end
      end
      default: begin
        return 1'b0;
      end
    endcase
    return 1'b1;
  endfunction

  // Queue one transaction, advancing the look-ahead copy; hand back its reply.
  function automatic rha_out_t queue_item(rha_action_e act, logic [HANDLE_W-1:0] h);
    rha_in_t  item;
    rha_out_t reply;
    item.action = act;
    item.handle = h;
    void'(apply_action(PLAN_COPY, item, reply));
    action_queue = {action_queue, item};
    return reply;
  endfunction

  // A live slot of the look-ahead copy where there is one, else any handle.
  function automatic logic [HANDLE_W-1:0] pick_live();
    int unsigned start;
    start = $urandom_range(0, POOL_SLOTS - 1);
    for (int unsigned k = 0; k < POOL_SLOTS; k++) begin
      if (slot_live[PLAN_COPY][(start + k) % POOL_SLOTS]) begin
        return HANDLE_W'((start + k) % POOL_SLOTS);
      end
    end
    return HANDLE_W'(start);
  endfunction

  task automatic queue_random(mix_e mix);
    int unsigned         r;
    int unsigned         cut_alloc;
    int unsigned         cut_retain;
    int unsigned         cut_release;
    int unsigned         cut_remove;
    logic [HANDLE_W-1:0] h;
    case (mix)
      MIX_GROW: begin
        cut_alloc = 70; cut_retain = 80; cut_release = 88; cut_remove = 92;
      end
      MIX_BALANCED: begin
        cut_alloc = 40; cut_retain = 55; cut_release = 75; cut_remove = 85;
      end
      default: begin
        cut_alloc = 8; cut_retain = 18; cut_release = 55; cut_remove = 90;
      end
    endcase
    r = $urandom_range(0, 99);
    // Mostly aim at live slots; now and then at any handle
    h = ($urandom_range(0, 11) == 0) ? HANDLE_W'($urandom) : pick_live();
    if (r < 4) begin
      void'(queue_item(rha_action_e'(3'($urandom_range(0, 7))), HANDLE_W'($urandom)));
    end else if (r < cut_alloc) begin
      void'(queue_item(ACT_ALLOC, HANDLE_W'($urandom)));
    end else if (r < cut_retain) begin
      void'(queue_item(ACT_RETAIN, h));
    end else if (r < cut_release) begin
      void'(queue_item(ACT_RELEASE, h));
    end else if (r < cut_remove) begin
      void'(queue_item(ACT_REMOVE, h));
    end else begin
      void'(queue_item(ACT_QUERY, h));
    end
  endtask

  // Driver: offer the queued transactions, with random gaps between them.
  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    rha_out_t reply;
    logic     nxt_valid;
    rha_in_t  nxt_item;
    if (!rst_ni) begin
      in_valid_i     <= 1'b0;
      in_item_i      <= '0;
      tx_gap_left    <= 0;
      accepted_items <= 0;
      all_sent       <= 1'b0;
      tail_phase     <= 1'b0;
    end else begin
      nxt_valid = in_valid_i;
      nxt_item  = in_item_i;
      if (in_valid_i && !in_stall_o) begin
        if (apply_action(CHECK_COPY, in_item_i, reply)) begin
          predicted_replies = {predicted_replies, reply};
        end
        accepted_items <= accepted_items + 1;
        nxt_valid = 1'b0;
      end
      if (!nxt_valid) begin
        if (tx_gap_left != 0) begin
          tx_gap_left <= tx_gap_left - 1;
        end else if (!tail_phase && !long_hold_on && !cycle_count[9] &&
                     $urandom_range(0, 15) == 0) begin
          // Start a random idle gap
          tx_gap_left <= $urandom_range(0, 16);
        end else if (action_queue.size() != 0) begin
          nxt_item  = action_queue.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid_i <= nxt_valid;
      in_item_i  <= nxt_item;
      all_sent   <= (action_queue.size() == 0) && !nxt_valid;
      tail_phase <= (action_queue.size() <= TAIL_ITEMS);
    end
  end

  function automatic void compare_field(string field, longint unsigned want,
                                        longint unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Monitor: check each reply against the oldest prediction, then decide the
  // stall for the next cycle.
  always @(posedge clk_i or negedge rst_ni) begin : monitor_proc
    rha_out_t    want;
    int unsigned nxt_gap;
    if (!rst_ni) begin
      out_stall_i    <= 1'b0;
      rx_gap_left    <= 0;
      long_hold_on   <= 1'b0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (predicted_replies.size() == 0) begin
          $error("reply with no transaction owed: status %0d, slot_out %0d",
                 out_item_o.status, out_item_o.slot_out);
          fail_count++;
        end else begin
          want = predicted_replies.pop_front();
          compare_field("status", 64'(want.status), 64'(out_item_o.status));
          compare_field("slot_out", 64'(want.slot_out), 64'(out_item_o.slot_out));
          compare_field("slot_freed", 64'(want.slot_freed), 64'(out_item_o.slot_freed));
          compare_field("count_out", 64'(want.count_out), 64'(out_item_o.count_out));
        end
      end
      nxt_gap = rx_gap_left;
      if (!long_hold_done && accepted_items >= HOLD_AT) begin
        // Hold off for a long stretch so that the block fills and stalls its input
        nxt_gap = HOLD_CYCLES;
        long_hold_done <= 1'b1;
        long_hold_on   <= 1'b1;
      end else if (nxt_gap != 0) begin
        nxt_gap--;
        if (nxt_gap == 0) long_hold_on <= 1'b0;
      end else if (!tail_phase && !(cycle_count[10] ^ cycle_count[8]) &&
                   $urandom_range(0, 15) == 0) begin
        nxt_gap = $urandom_range(1, 17);
      end
      rx_gap_left <= nxt_gap;
      out_stall_i <= (nxt_gap != 0);
    end
  end

  // Watchdog: end the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      cycle_count <= cycle_count + 1;
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles == STUCK_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin : stimulus_proc
    mix_e plan[$];

    for (int c = 0; c < 2; c++) begin
      stack_depth[c] = 0;
      live_total[c]  = 0;
      for (int unsigned s = 0; s < POOL_SLOTS; s++) begin
        slot_live[c][s]  = 1'b0;
        slot_count[c][s] = '0;
        free_stack[c][s] = 0;
      end
    end

    // Directed: absent handles, fresh slots, count up and down, LIFO reuse,
    // undefined codes
    void'(queue_item(ACT_QUERY, 8'd0));
    void'(queue_item(ACT_RETAIN, 8'd255));
    void'(queue_item(ACT_RELEASE, 8'd128));
    void'(queue_item(ACT_REMOVE, 8'd127));
    void'(queue_item(ACT_ALLOC, 8'd255));
    void'(queue_item(ACT_ALLOC, 8'd0));
    void'(queue_item(ACT_ALLOC, 8'd170));
    void'(queue_item(ACT_RETAIN, 8'd0));
    void'(queue_item(ACT_QUERY, 8'd0));
    void'(queue_item(ACT_RELEASE, 8'd0));
    void'(queue_item(ACT_RELEASE, 8'd0));
    void'(queue_item(ACT_RELEASE, 8'd0));
    void'(queue_item(ACT_REMOVE, 8'd1));
    void'(queue_item(ACT_ALLOC, 8'd85));
    void'(queue_item(ACT_ALLOC, 8'd0));
    void'(queue_item(ACT_ALLOC, 8'd0));
    void'(queue_item(ACT_QUERY, 8'd2));
    for (int k = 0; k < 3; k++) begin
      void'(queue_item(rha_action_e'(FIRST_UNDEF_ACT + 3'(k)), (k == 1) ? 8'd255 : 8'd0));
    end
    void'(queue_item(ACT_QUERY, 8'd1));
    void'(queue_item(ACT_REMOVE, 8'd2));
    void'(queue_item(ACT_REMOVE, 8'd3));

    // Random phases: fill to the pool limit, drain to empty, and again
    plan = '{MIX_GROW, MIX_GROW, MIX_GROW, MIX_GROW, MIX_GROW, MIX_BALANCED,
             MIX_SHRINK, MIX_SHRINK, MIX_SHRINK, MIX_SHRINK, MIX_SHRINK, MIX_SHRINK,
             MIX_BALANCED, MIX_GROW, MIX_GROW, MIX_GROW};
    foreach (plan[p]) begin
      for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
        queue_random(plan[p]);
        if (live_total[PLAN_COPY] == POOL_SLOTS && $urandom_range(0, 15) == 0) begin
          // Full pool: touch the top slot and try one allocation too many
          void'(queue_item(ACT_RETAIN, 8'd255));
          void'(queue_item(ACT_QUERY, 8'd255));
          void'(queue_item(ACT_ALLOC, HANDLE_W'($urandom)));
        end
      end
    end

    for (int unsigned n = 0; n < PHASE_ITEMS / 4; n++) queue_random(MIX_BALANCED);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (!(all_sent && predicted_replies.size() == 0)) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
